// ===== sv/bic_pkg.sv =====
package bic_pkg;

    // Default coordinate and weight formats
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Integer bits (sign included) of the signed weight format
    localparam int WEIGHT_INT_BITS = 4;

    // Clamp applied to each quotient magnitude before u is formed
    localparam int QCAP_LOG2 = 60;

    // Sideband that travels with an item through the divider
    typedef struct packed {
        logic neg_v;
        logic neg_w;
        logic deg;
    } bic_tag_t;

endpackage

// ===== sv/bic_front.sv =====
module bic_front #(
    parameter int COORD_WIDTH = bic_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [COORD_WIDTH-1:0]       px,
    input  logic signed [COORD_WIDTH-1:0]       py,
    input  logic signed [COORD_WIDTH-1:0]       ax,
    input  logic signed [COORD_WIDTH-1:0]       ay,
    input  logic signed [COORD_WIDTH-1:0]       bx,
    input  logic signed [COORD_WIDTH-1:0]       by,
    input  logic signed [COORD_WIDTH-1:0]       cx,
    input  logic signed [COORD_WIDTH-1:0]       cy,
    output logic                                out_valid,
    output logic [2*COORD_WIDTH+2:0]            den_mag,
    output logic [2*COORD_WIDTH+2:0]            nv_mag,
    output logic [2*COORD_WIDTH+2:0]            nw_mag,
    output bic_pkg::bic_tag_t                   tag
);
    import bic_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int CRW = PW + 1;

    logic v1_reg, v2_reg, v3_reg;

    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    logic signed [CRW-1:0] den_c, nv_c, nw_c;
    logic [CRW-1:0] den_mag_reg, nv_mag_reg, nw_mag_reg;
    bic_tag_t tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // edge vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            e0x_reg <= DW'(bx) - DW'(ax);
            e0y_reg <= DW'(by) - DW'(ay);
            e1x_reg <= DW'(cx) - DW'(ax);
            e1y_reg <= DW'(cy) - DW'(ay);
            e2x_reg <= DW'(px) - DW'(ax);
            e2y_reg <= DW'(py) - DW'(ay);
        end
    end

    // cross-product terms
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= PW'(e0x_reg) * PW'(e1y_reg);
            p1_reg <= PW'(e0y_reg) * PW'(e1x_reg);
            p2_reg <= PW'(e2x_reg) * PW'(e1y_reg);
            p3_reg <= PW'(e2y_reg) * PW'(e1x_reg);
            p4_reg <= PW'(e0x_reg) * PW'(e2y_reg);
            p5_reg <= PW'(e0y_reg) * PW'(e2x_reg);
        end
    end

    always_comb begin
        den_c = CRW'(p0_reg) - CRW'(p1_reg);
        nv_c  = CRW'(p2_reg) - CRW'(p3_reg);
        nw_c  = CRW'(p4_reg) - CRW'(p5_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_mag_reg   <= den_c[CRW-1] ? CRW'(-den_c) : CRW'(den_c);
            nv_mag_reg    <= nv_c[CRW-1]  ? CRW'(-nv_c)  : CRW'(nv_c);
            nw_mag_reg    <= nw_c[CRW-1]  ? CRW'(-nw_c)  : CRW'(nw_c);
            tag_reg.neg_v <= nv_c[CRW-1] ^ den_c[CRW-1];
            tag_reg.neg_w <= nw_c[CRW-1] ^ den_c[CRW-1];
            tag_reg.deg   <= (den_c == '0);
        end
    end

    assign out_valid = v3_reg;
    assign den_mag   = den_mag_reg;
    assign nv_mag    = nv_mag_reg;
    assign nw_mag    = nw_mag_reg;
    assign tag       = tag_reg;

endmodule

// ===== sv/bic_div.sv =====
module bic_div #(
    parameter int MW = 35,
    parameter int FRAC = bic_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [MW-1:0]             den_mag,
    input  logic [MW-1:0]             nv_mag,
    input  logic [MW-1:0]             nw_mag,
    input  bic_pkg::bic_tag_t         in_tag,
    output logic                      out_valid,
    output logic [MW+FRAC-1:0]        qv,
    output logic [MW+FRAC-1:0]        qw,
    output bic_pkg::bic_tag_t         out_tag
);
    import bic_pkg::*;

    localparam int NW = MW + FRAC;

    logic [MW-1:0] vrem [0:NW];
    logic [MW-1:0] wrem [0:NW];
    logic [NW-1:0] vnum [0:NW];
    logic [NW-1:0] wnum [0:NW];
    logic [NW-1:0] vq   [0:NW];
    logic [NW-1:0] wq   [0:NW];
    logic [MW-1:0] dd   [0:NW];
    bic_tag_t      tg   [0:NW];
    logic          vl   [0:NW];

    assign vrem[0] = '0;
    assign wrem[0] = '0;
    assign vnum[0] = {nv_mag, {FRAC{1'b0}}};
    assign wnum[0] = {nw_mag, {FRAC{1'b0}}};
    assign vq[0]   = '0;
    assign wq[0]   = '0;
    assign dd[0]   = den_mag;
    assign tg[0]   = in_tag;
    assign vl[0]   = in_valid;

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [MW:0]   rv2, rw2;
        logic          gev, gew;
        logic [MW-1:0] rv_reg, rw_reg, d_reg;
        logic [NW-1:0] nv_reg, nw_reg, qv_reg, qw_reg;
        bic_tag_t      t_reg;
        logic          v_reg;

        always_comb begin
            rv2 = {vrem[k], vnum[k][NW-1]};
            rw2 = {wrem[k], wnum[k][NW-1]};
            gev = (rv2 >= {1'b0, dd[k]});
            gew = (rw2 >= {1'b0, dd[k]});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= vl[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rv_reg <= gev ? MW'(rv2 - {1'b0, dd[k]}) : MW'(rv2);
                rw_reg <= gew ? MW'(rw2 - {1'b0, dd[k]}) : MW'(rw2);
                nv_reg <= {vnum[k][NW-2:0], 1'b0};
                nw_reg <= {wnum[k][NW-2:0], 1'b0};
                qv_reg <= {vq[k][NW-2:0], gev};
                qw_reg <= {wq[k][NW-2:0], gew};
                d_reg  <= dd[k];
                t_reg  <= tg[k];
            end
        end

        assign vrem[k+1] = rv_reg;
        assign wrem[k+1] = rw_reg;
        assign vnum[k+1] = nv_reg;
        assign wnum[k+1] = nw_reg;
        assign vq[k+1]   = qv_reg;
        assign wq[k+1]   = qw_reg;
        assign dd[k+1]   = d_reg;
        assign tg[k+1]   = t_reg;
        assign vl[k+1]   = v_reg;
    end

    assign out_valid = vl[NW];
    assign qv        = vq[NW];
    assign qw        = wq[NW];
    assign out_tag   = tg[NW];

endmodule

// ===== sv/bic_post.sv =====
module bic_post #(
    parameter int NW = 51,
    parameter int FRAC = bic_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic [NW-1:0]                                qv,
    input  logic [NW-1:0]                                qw,
    input  bic_pkg::bic_tag_t                            in_tag,
    output logic                                         out_valid,
    output logic signed [FRAC+bic_pkg::WEIGHT_INT_BITS-1:0] u_out,
    output logic signed [FRAC+bic_pkg::WEIGHT_INT_BITS-1:0] v_out,
    output logic signed [FRAC+bic_pkg::WEIGHT_INT_BITS-1:0] w_out,
    output logic                                         inside_out,
    output logic                                         deg_out
);
    import bic_pkg::*;

    localparam int OW = FRAC + WEIGHT_INT_BITS;
    localparam int SW = ((NW > QCAP_LOG2 + 1) ? NW : QCAP_LOG2 + 1) + 3;
    localparam logic [SW-1:0] QCAP = SW'(1) << QCAP_LOG2;
    localparam logic signed [SW-1:0] ONE  = SW'(1) << FRAC;
    localparam logic signed [SW-1:0] OMAX = (SW'(1) << (OW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] OMIN = -OMAX - SW'(1);

    logic [SW-1:0] cv, cw;
    logic signed [SW-1:0] sv, sw, su;
    logic signed [OW-1:0] u_sat, v_sat, w_sat;

    logic                 valid_reg;
    logic signed [OW-1:0] u_reg, v_reg, w_reg;
    logic                 inside_reg, deg_reg;

    always_comb begin
        cv = SW'(qv);
        cw = SW'(qw);
        if (cv > QCAP) cv = QCAP;
        if (cw > QCAP) cw = QCAP;
        sv = in_tag.neg_v ? -$signed(cv) : $signed(cv);
        sw = in_tag.neg_w ? -$signed(cw) : $signed(cw);
        su = ONE - sv - sw;
        u_sat = (su > OMAX) ? OW'(OMAX) : ((su < OMIN) ? OW'(OMIN) : OW'(su));
        v_sat = (sv > OMAX) ? OW'(OMAX) : ((sv < OMIN) ? OW'(OMIN) : OW'(sv));
        w_sat = (sw > OMAX) ? OW'(OMAX) : ((sw < OMIN) ? OW'(OMIN) : OW'(sw));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg <= in_tag.deg;
            if (in_tag.deg) begin
                u_reg      <= '0;
                v_reg      <= '0;
                w_reg      <= '0;
                inside_reg <= 1'b0;
            end else begin
                u_reg      <= u_sat;
                v_reg      <= v_sat;
                w_reg      <= w_sat;
                inside_reg <= !u_sat[OW-1] && !v_sat[OW-1] && !w_sat[OW-1];
            end
        end
    end

    assign out_valid  = valid_reg;
    assign u_out      = u_reg;
    assign v_out      = v_reg;
    assign w_out      = w_reg;
    assign inside_out = inside_reg;
    assign deg_out    = deg_reg;

endmodule

// ===== sv/barycentric_inside_test.sv =====
// Barycentric point-in-triangle test. Each transaction carries a point P and
// triangle vertices A, B, C as signed fixed-point coordinates; the result
// transaction returns the weights u, v, w of A, B, C in signed
// Q3.WEIGHT_FRAC_BITS (each saturated), an inside flag (all weights >= 0)
// and a degenerate flag (zero-area triangle: weights then read zero and
// inside is low). v and w are the exact ratios cross(P-A,C-A)/cross(B-A,C-A)
// and cross(B-A,P-A)/cross(B-A,C-A), truncated toward zero; u = 1 - v - w.
// One transaction is accepted every clock while the result side keeps up.
// Three front stages form edge vectors, cross products and magnitudes,
// then a restoring divider resolves one quotient bit per stage for both
// weights at once, and a final stage clamps, recombines and saturates.
// The whole pipeline advances together; when a result is held on m_ready
// low, the pipe and s_ready hold with it, so nothing is lost.
module barycentric_inside_test #(
    parameter int COORD_WIDTH      = bic_pkg::COORD_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = bic_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_WIDTH-1:0]          s_point_x,
    input  logic signed [COORD_WIDTH-1:0]          s_point_y,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_a_x,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_a_y,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_b_x,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_b_y,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_c_x,
    input  logic signed [COORD_WIDTH-1:0]          s_vert_c_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [WEIGHT_FRAC_BITS+bic_pkg::WEIGHT_INT_BITS-1:0] m_weight_u,
    output logic signed [WEIGHT_FRAC_BITS+bic_pkg::WEIGHT_INT_BITS-1:0] m_weight_v,
    output logic signed [WEIGHT_FRAC_BITS+bic_pkg::WEIGHT_INT_BITS-1:0] m_weight_w,
    output logic                                   m_inside_res,
    output logic                                   m_degenerate
);
    import bic_pkg::*;

    // magnitude width of a cross product, and numerator width of the divide
    localparam int MW = 2 * COORD_WIDTH + 3;
    localparam int NW = MW + WEIGHT_FRAC_BITS;

    logic          en;
    logic          f_valid, d_valid;
    logic [MW-1:0] den_mag, nv_mag, nw_mag;
    logic [NW-1:0] qv, qw;
    bic_tag_t      f_tag, d_tag;

    // advance every stage unless the output holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    bic_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .px        (s_point_x),
        .py        (s_point_y),
        .ax        (s_vert_a_x),
        .ay        (s_vert_a_y),
        .bx        (s_vert_b_x),
        .by        (s_vert_b_y),
        .cx        (s_vert_c_x),
        .cy        (s_vert_c_y),
        .out_valid (f_valid),
        .den_mag   (den_mag),
        .nv_mag    (nv_mag),
        .nw_mag    (nw_mag),
        .tag       (f_tag)
    );

    bic_div #(
        .MW   (MW),
        .FRAC (WEIGHT_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .den_mag   (den_mag),
        .nv_mag    (nv_mag),
        .nw_mag    (nw_mag),
        .in_tag    (f_tag),
        .out_valid (d_valid),
        .qv        (qv),
        .qw        (qw),
        .out_tag   (d_tag)
    );

    bic_post #(
        .NW   (NW),
        .FRAC (WEIGHT_FRAC_BITS)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d_valid),
        .qv         (qv),
        .qw         (qw),
        .in_tag     (d_tag),
        .out_valid  (m_valid),
        .u_out      (m_weight_u),
        .v_out      (m_weight_v),
        .w_out      (m_weight_w),
        .inside_out (m_inside_res),
        .deg_out    (m_degenerate)
    );

endmodule

// ===== sv/bic_checker.sv =====
module bic_checker #(
    parameter int OUT_W = bic_pkg::WEIGHT_FRAC_BITS_DEF + bic_pkg::WEIGHT_INT_BITS
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_weight_u,
    input logic signed [OUT_W-1:0] m_weight_v,
    input logic signed [OUT_W-1:0] m_weight_w,
    input logic                    m_inside_res,
    input logic                    m_degenerate
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_weight_u) && $stable(m_inside_res))
        else $error("result dropped or changed while stalled");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_weight_u == '0 && m_weight_v == '0 && m_weight_w == '0 && !m_inside_res)
        else $error("degenerate result carries weights or inside");

    a_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            m_inside_res == (!m_weight_u[OUT_W-1] && !m_weight_v[OUT_W-1]
                             && !m_weight_w[OUT_W-1]))
        else $error("inside flag disagrees with weight signs");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

bind barycentric_inside_test bic_checker #(
    .OUT_W (WEIGHT_FRAC_BITS + bic_pkg::WEIGHT_INT_BITS)
) u_bic_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_weight_u   (m_weight_u),
    .m_weight_v   (m_weight_v),
    .m_weight_w   (m_weight_w),
    .m_inside_res (m_inside_res),
    .m_degenerate (m_degenerate)
);
